// ===== hw/rtl/atce_pkg.sv =====
// Shared types, constants and the SGR helper function for the ANSI terminal cursor engine.
package atce_pkg;

    localparam int NUM_PARAMS = 3;
    localparam int IDX_W      = (NUM_PARAMS > 1) ? $clog2(NUM_PARAMS) : 1;
    localparam int NUM_W      = $clog2(NUM_PARAMS + 1);
    localparam int POS_W      = 17;
    localparam int P1_SEL     = 1 % NUM_PARAMS;

    localparam int CHAR_W = 16;
    localparam int DIM_W  = 8;
    localparam int ATTR_W = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h17;
    localparam logic [DIM_W-1:0]  COLS_RESET = 8'd80;
    localparam logic [DIM_W-1:0]  ROWS_RESET = 8'd25;

    typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;
    typedef logic [CFG_DATA_W-1:0] cfg_data_t;
    typedef logic [CHAR_W-1:0]     char_t;

    localparam cfg_idx_t CFG_COLUMNS      = 2'd0;
    localparam cfg_idx_t CFG_ROWS         = 2'd1;
    localparam cfg_idx_t CFG_DEFAULT_ATTR = 2'd2;

    // control characters and CSI finals
    localparam char_t CH_ESC   = 16'd27;
    localparam char_t CH_TAB   = 16'd9;
    localparam char_t CH_LF    = 16'd10;
    localparam char_t CH_CR    = 16'd13;
    localparam char_t CH_BS    = 16'd8;
    localparam char_t CH_LBRKT = 16'd91;
    localparam char_t CH_SEMI  = 16'd59;
    localparam char_t CH_ZERO  = 16'd48;
    localparam char_t CH_NINE  = 16'd57;
    localparam char_t CMD_CUP  = 16'd72;   // H
    localparam char_t CMD_HVP  = 16'd102;  // f
    localparam char_t CMD_CUU  = 16'd65;   // A
    localparam char_t CMD_CUD  = 16'd66;   // B
    localparam char_t CMD_CUF  = 16'd67;   // C
    localparam char_t CMD_CUB  = 16'd68;   // D
    localparam char_t CMD_SCP  = 16'd115;  // s
    localparam char_t CMD_RCP  = 16'd117;  // u
    localparam char_t CMD_ED   = 16'd74;   // J
    localparam char_t CMD_EL   = 16'd75;   // K
    localparam char_t CMD_SGR  = 16'd109;  // m

    localparam logic [15:0] SGR_RESET   = 16'd0;
    localparam logic [15:0] SGR_BRIGHT  = 16'd1;
    localparam logic [15:0] SGR_BLINK   = 16'd5;
    localparam logic [15:0] SGR_REVERSE = 16'd7;
    localparam logic [15:0] SGR_CONCEAL = 16'd8;
    localparam logic [15:0] SGR_FG_LO   = 16'd30;
    localparam logic [15:0] SGR_FG_HI   = 16'd37;
    localparam logic [15:0] SGR_BG_LO   = 16'd40;
    localparam logic [15:0] SGR_BG_HI   = 16'd47;

    localparam logic [2:0] COLOUR_MAP [8] = '{3'd0, 3'd4, 3'd2, 3'd6,
                                              3'd1, 3'd5, 3'd3, 3'd7};

    typedef enum logic [2:0] {
        MODE_NORMAL = 3'b001,
        MODE_ESC    = 3'b010,
        MODE_CSI    = 3'b100
    } mode_t;

    typedef enum logic [1:0] {
        ACT_NONE         = 2'd0,
        ACT_DRAW         = 2'd1,
        ACT_CLEAR_SCREEN = 2'd2,
        ACT_CLEAR_EOL    = 2'd3
    } action_t;

    typedef struct packed {
        action_t           action;
        logic [DIM_W-1:0]  draw_col;
        logic [DIM_W-1:0]  draw_row;
        char_t             draw_char;
        logic [ATTR_W-1:0] draw_attr;
        logic [15:0]       scroll_lines;
        logic [DIM_W-1:0]  cursor_col;
        logic [DIM_W-1:0]  cursor_row;
    } result_t;

    function automatic logic [ATTR_W-1:0] sgr_apply(input logic [ATTR_W-1:0] a,
                                                    input logic [15:0] p);
        logic [ATTR_W-1:0] r;
        logic [15:0]       d;
        r = a;
        d = 16'd0;
        if (p == SGR_RESET) begin
            r = a & 8'h77;
        end
        else if (p == SGR_BRIGHT) begin
            r = a | 8'h08;
        end
        else if (p == SGR_BLINK) begin
            r = a | 8'h80;
        end
        else if (p == SGR_REVERSE) begin
            r = {a[3:0], a[7:4]};
        end
        else if (p == SGR_CONCEAL) begin
            r = {a[3:0], a[3:0]};
        end
        else if (p >= SGR_FG_LO && p <= SGR_FG_HI) begin
            d = p - SGR_FG_LO;
            r = {a[7:4], 1'b0, COLOUR_MAP[d[2:0]]};
        end
        else if (p >= SGR_BG_LO && p <= SGR_BG_HI) begin
            d = p - SGR_BG_LO;
            r = {1'b0, COLOUR_MAP[d[2:0]], a[3:0]};
        end
        return r;
    endfunction

endpackage

// ===== hw/rtl/atce_if.sv =====
// Handshake interfaces for the character input and the result output channels.
interface atce_char_if;
    import atce_pkg::*;
    logic  valid;
    logic  ready;
    char_t char_code;
    modport source (output valid, output char_code, input ready);
    modport sink   (input valid, input char_code, output ready);
endinterface

interface atce_res_if;
    import atce_pkg::*;
    logic              valid;
    logic              ready;
    logic [1:0]        action;
    logic [DIM_W-1:0]  draw_col;
    logic [DIM_W-1:0]  draw_row;
    char_t             draw_char;
    logic [ATTR_W-1:0] draw_attr;
    logic [15:0]       scroll_lines;
    logic [DIM_W-1:0]  cursor_col;
    logic [DIM_W-1:0]  cursor_row;
    modport source (output valid, output action, output draw_col, output draw_row,
                    output draw_char, output draw_attr, output scroll_lines,
                    output cursor_col, output cursor_row, input ready);
    modport sink   (input valid, input action, input draw_col, input draw_row,
                    input draw_char, input draw_attr, input scroll_lines,
                    input cursor_col, input cursor_row, output ready);
endinterface

// ===== hw/rtl/ansi_terminal_cursor_engine_top.sv =====
// Top level of the ANSI terminal cursor engine.
//
//   channel   dir   handshake            payload
//   char_in   in    valid/ready          char_code[15:0]
//   res_out   out   valid/ready          action, draw_col/row, draw_char, draw_attr,
//                                        scroll_lines, cursor_col/row
//   cfg       in    cfg_we (no stall)    cfg_index[1:0], cfg_data[7:0]
//
// One word in per cycle while res_out does not stall, one result word out per word in.
// Path: an accepted word is held in the input register, then its result in the result register.
// The step logic is combinational between the two registers.
// Reset clears parser, cursor and saved cursor, loads 80x25 and attribute 0x17.
// A stalled result holds the input register; a full input register that is not taken stalls char_in.
module ansi_terminal_cursor_engine_top (
    input  logic                clk,
    input  logic                rst_n,
    atce_char_if.sink           char_in,
    atce_res_if.source          res_out,
    input  logic                cfg_we,
    input  atce_pkg::cfg_idx_t  cfg_index,
    input  atce_pkg::cfg_data_t cfg_data
);
    import atce_pkg::*;

    logic    item_valid;
    char_t   item_char;
    logic    step;
    logic    res_space;
    result_t res;

    atce_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .char_in    (char_in),
        .take       (step),
        .item_valid (item_valid),
        .item_char  (item_char)
    );

    atce_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_char  (item_char),
        .res_space  (res_space),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .step       (step),
        .res        (res)
    );

    atce_out_stage u_out_stage (
        .clk     (clk),
        .rst_n   (rst_n),
        .load    (step),
        .res     (res),
        .space   (res_space),
        .res_out (res_out)
    );
endmodule

// ===== hw/rtl/atce_in_stage.sv =====
// Input register: holds one accepted character word for the step logic.
module atce_in_stage (
    input  logic            clk,
    input  logic            rst_n,
    atce_char_if.sink       char_in,
    input  logic            take,
    output logic            item_valid,
    output atce_pkg::char_t item_char
);
    import atce_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    char_t char_reg;

    assign char_in.ready = !valid_reg || take;
    assign valid_next    = char_in.valid || (valid_reg && !take);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (char_in.ready)
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (char_in.valid && char_in.ready)
        begin
            char_reg <= char_in.char_code;
        end
    end

    assign item_valid = valid_reg;
    assign item_char  = char_reg;
endmodule

// ===== hw/rtl/atce_core.sv =====
// Step logic: parser, cursor, attribute and window state, one character per cycle while the result register has space.
module atce_core (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        item_valid,
    input  atce_pkg::char_t             item_char,
    input  logic                        res_space,
    input  logic                        cfg_we,
    input  atce_pkg::cfg_idx_t          cfg_index,
    input  atce_pkg::cfg_data_t         cfg_data,
    output logic                        step,
    output atce_pkg::result_t           res
);
    import atce_pkg::*;

    mode_t             mode_reg, mode_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [15:0]       pv_reg  [NUM_PARAMS];
    logic [15:0]       pv_next [NUM_PARAMS];
    logic [DIM_W-1:0]  col_reg, col_next, row_reg, row_next;
    logic [DIM_W-1:0]  scol_reg, scol_next, srow_reg, srow_next;
    logic [ATTR_W-1:0] attr_reg, attr_next;
    logic [DIM_W-1:0]  cols_reg, rows_reg;

    logic [DIM_W-1:0]  eff_w, eff_h;
    logic [POS_W-1:0]  w_ext, h_ext, wx, wy, n_lines;
    logic [IDX_W-1:0]  k;
    logic [NUM_W-1:0]  num;
    logic [15:0]       p0, p1, pk, lines;
    logic [19:0]       acc;
    logic [3:0]        digit;
    logic              settle;
    action_t           act;
    logic [DIM_W-1:0]  act_col, act_row;
    char_t             dchar;

    assign step  = item_valid && res_space;
    assign eff_w = (cols_reg == '0) ? DIM_W'(1) : cols_reg;
    assign eff_h = (rows_reg == '0) ? DIM_W'(1) : rows_reg;
    assign w_ext = POS_W'(eff_w);
    assign h_ext = POS_W'(eff_h);

    always_comb
    begin
        mode_next = mode_reg;
        idx_next  = idx_reg;
        pv_next   = pv_reg;
        scol_next = scol_reg;
        srow_next = srow_reg;
        attr_next = attr_reg;
        wx        = POS_W'(col_reg);
        wy        = POS_W'(row_reg);
        act       = ACT_NONE;
        act_col   = '0;
        act_row   = '0;
        dchar     = '0;
        settle    = 1'b1;
        lines     = '0;
        n_lines   = '0;
        k         = (32'(idx_reg) < NUM_PARAMS) ? idx_reg : IDX_W'(NUM_PARAMS - 1);
        num       = NUM_W'(k) + NUM_W'(1);
        p0        = pv_reg[0];
        p1        = pv_reg[P1_SEL];
        pk        = pv_reg[k];
        digit     = 4'(item_char - CH_ZERO);
        acc       = {1'b0, pk, 3'b000} + {3'b000, pk, 1'b0} + 20'(digit);

        case (mode_reg)
            MODE_NORMAL:
            begin
                if (item_char == CH_ESC)
                begin
                    mode_next = MODE_ESC;
                end
                else if (item_char == CH_TAB)
                begin
                    wx = (wx + POS_W'(4)) & ~POS_W'(3);
                    if (wx >= w_ext)
                    begin
                        wx = '0;
                        wy = wy + POS_W'(1);
                    end
                end
                else if (item_char == CH_LF)
                begin
                    wx = '0;
                    wy = wy + POS_W'(1);
                end
                else if (item_char == CH_CR)
                begin
                    wx = '0;
                end
                else if (item_char == CH_BS)
                begin
                    if (wx != '0)
                    begin
                        wx = wx - POS_W'(1);
                    end
                end
                else
                begin
                    act     = ACT_DRAW;
                    act_col = col_reg;
                    act_row = row_reg;
                    dchar   = item_char;
                    wx      = wx + POS_W'(1);
                end
            end
            MODE_ESC:
            begin
                if (item_char == CH_LBRKT)
                begin
                    mode_next  = MODE_CSI;
                    idx_next   = '0;
                    pv_next[0] = '0;
                end
                else
                begin
                    mode_next = MODE_NORMAL;
                    settle    = 1'b0;
                end
            end
            MODE_CSI:
            begin
                if (item_char >= CH_ZERO && item_char <= CH_NINE)
                begin
                    pv_next[k] = (acc > 20'hffff) ? 16'hffff : acc[15:0];
                end
                else if (item_char == CH_SEMI && 32'(k) < NUM_PARAMS - 1)
                begin
                    idx_next          = k + IDX_W'(1);
                    pv_next[idx_next] = '0;
                end
                else
                begin
                    mode_next = MODE_NORMAL;
                    case (item_char)
                        CMD_CUP, CMD_HVP:
                        begin
                            wy = (p0 < 16'(eff_h - 8'd1)) ? POS_W'(p0)
                                                          : POS_W'(eff_h - 8'd1);
                            if (num > NUM_W'(1))
                            begin
                                wx = (p1 < 16'(eff_w - 8'd1)) ? POS_W'(p1)
                                                              : POS_W'(eff_w - 8'd1);
                            end
                        end
                        CMD_CUU:
                        begin
                            if (wy >= POS_W'(p0))
                            begin
                                wy = wy - POS_W'(p0);
                            end
                        end
                        CMD_CUD:
                        begin
                            if (wy < h_ext + POS_W'(p0))
                            begin
                                wy = wy + POS_W'(p0);
                            end
                        end
                        CMD_CUF:
                        begin
                            if (wx < w_ext + POS_W'(p0))
                            begin
                                wx = wx + POS_W'(p0);
                            end
                        end
                        CMD_CUB:
                        begin
                            if (wx >= POS_W'(p0))
                            begin
                                wx = wx - POS_W'(p0);
                            end
                        end
                        CMD_SCP:
                        begin
                            scol_next = col_reg;
                            srow_next = row_reg;
                        end
                        CMD_RCP:
                        begin
                            wx = POS_W'(scol_reg);
                            wy = POS_W'(srow_reg);
                        end
                        CMD_ED:
                        begin
                            act = ACT_CLEAR_SCREEN;
                            wx  = '0;
                            wy  = '0;
                        end
                        CMD_EL:
                        begin
                            act     = ACT_CLEAR_EOL;
                            act_col = col_reg;
                            act_row = row_reg;
                        end
                        CMD_SGR:
                        begin
                            for (int i = 0; i < NUM_PARAMS; i++)
                            begin
                                if (NUM_W'(i) < num)
                                begin
                                    attr_next = sgr_apply(attr_next, pv_reg[i]);
                                end
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            default:
            begin
                mode_next = MODE_NORMAL;
            end
        endcase

        if (settle)
        begin
            if (wx >= w_ext)
            begin
                wx = '0;
                wy = wy + POS_W'(1);
            end
            if (wy >= h_ext)
            begin
                n_lines = wy - h_ext + POS_W'(1);
                lines   = (n_lines > POS_W'(16'hffff)) ? 16'hffff : n_lines[15:0];
                wy      = h_ext - POS_W'(1);
            end
        end

        col_next = wx[DIM_W-1:0];
        row_next = wy[DIM_W-1:0];

        res.action       = act;
        res.draw_col     = act_col;
        res.draw_row     = act_row;
        res.draw_char    = dchar;
        res.draw_attr    = attr_next;
        res.scroll_lines = lines;
        res.cursor_col   = col_next;
        res.cursor_row   = row_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_NORMAL;
            idx_reg  <= '0;
            for (int i = 0; i < NUM_PARAMS; i++)
            begin
                pv_reg[i] <= '0;
            end
            col_reg  <= '0;
            row_reg  <= '0;
            scol_reg <= '0;
            srow_reg <= '0;
            attr_reg <= ATTR_RESET;
            cols_reg <= COLS_RESET;
            rows_reg <= ROWS_RESET;
        end
        else
        begin
            if (step)
            begin
                mode_reg <= mode_next;
                idx_reg  <= idx_next;
                pv_reg   <= pv_next;
                col_reg  <= col_next;
                row_reg  <= row_next;
                scol_reg <= scol_next;
                srow_reg <= srow_next;
                attr_reg <= attr_next;
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_COLUMNS:      cols_reg <= cfg_data;
                    CFG_ROWS:         rows_reg <= cfg_data;
                    CFG_DEFAULT_ATTR: attr_reg <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end
        end
    end
endmodule

// ===== hw/rtl/atce_out_stage.sv =====
// Result register: holds one finished result word until the sink takes it.
module atce_out_stage (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  atce_pkg::result_t res,
    output logic              space,
    atce_res_if.source        res_out
);
    import atce_pkg::*;

    logic    valid_reg;
    result_t res_reg;

    assign space = !valid_reg || res_out.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (space)
        begin
            valid_reg <= load;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res;
        end
    end

    assign res_out.valid        = valid_reg;
    assign res_out.action       = res_reg.action;
    assign res_out.draw_col     = res_reg.draw_col;
    assign res_out.draw_row     = res_reg.draw_row;
    assign res_out.draw_char    = res_reg.draw_char;
    assign res_out.draw_attr    = res_reg.draw_attr;
    assign res_out.scroll_lines = res_reg.scroll_lines;
    assign res_out.cursor_col   = res_reg.cursor_col;
    assign res_out.cursor_row   = res_reg.cursor_row;
endmodule
